// File: rtl/lcdsd_pkg.sv
// Shared constants, types and the microcode table of the LCD shadow draw serializer.
`timescale 1ns / 1ps
package lcdsd_pkg;

  // Display geometry
  localparam int ROWS          = 64;
  localparam int WORDS_PER_ROW = 8;
  localparam int MAX_COL       = 16 * WORDS_PER_ROW - 1;

  // Frame store: entry row*8 + word
  localparam int FB_DEPTH = 512;
  localparam int FB_AW    = 9;
  localparam int FB_W     = 16;

  // Serial framing bytes
  localparam logic [7:0] SYNC_CMD  = 8'hF8;
  localparam logic [7:0] SYNC_DATA = 8'hFA;
  localparam logic [7:0] ADDR_BASE = 8'h80;

  // Microprogram steps
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ROW_SY  = 4'd1;
  localparam logic [3:0] ST_ROW_HI  = 4'd2;
  localparam logic [3:0] ST_ROW_LO  = 4'd3;
  localparam logic [3:0] ST_COL_SY  = 4'd4;
  localparam logic [3:0] ST_COL_HI  = 4'd5;
  localparam logic [3:0] ST_COL_LO  = 4'd6;
  localparam logic [3:0] ST_RD      = 4'd7;
  localparam logic [3:0] ST_WR      = 4'd8;
  localparam logic [3:0] ST_DH_SY   = 4'd9;
  localparam logic [3:0] ST_DH_HI   = 4'd10;
  localparam logic [3:0] ST_DH_LO   = 4'd11;
  localparam logic [3:0] ST_DL_SY   = 4'd12;
  localparam logic [3:0] ST_DL_HI   = 4'd13;
  localparam logic [3:0] ST_DL_LO   = 4'd14;
  localparam logic [3:0] ST_CLR     = 4'd15;

  // Which part of a framed byte goes out
  typedef enum logic [1:0] {
    K_SYNC = 2'd0,
    K_HI   = 2'd1,
    K_LO   = 2'd2
  } kind_t;

  // Which command or data byte is framed
  typedef enum logic [1:0] {
    V_ROW = 2'd0,
    V_COL = 2'd1,
    V_DHI = 2'd2,
    V_DLO = 2'd3
  } vsel_t;

  // Sequencing condition of a step
  typedef enum logic [1:0] {
    C_NEXT = 2'd0,
    C_WAIT = 2'd1,
    C_LOOP = 2'd2,
    C_CLR  = 2'd3
  } cond_t;

  typedef struct packed {
    logic       take_in;
    logic       emit;
    kind_t      kind;
    vsel_t      vsel;
    logic       sync_data;
    logic       rd;
    logic       wr;
    logic       clr;
    logic       last_chk;
    cond_t      cond;
    logic [3:0] target;
  } uc_t;

  // Gated control from sequencer to datapath
  typedef struct packed {
    logic  take_in;
    logic  load_in;
    logic  emit_go;
    kind_t kind;
    vsel_t vsel;
    logic  sync_data;
    logic  last_chk;
    logic  rd;
    logic  wr;
    logic  clr;
    logic  w_inc;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_fire;
    logic in_skip;
    logic out_free;
    logic word_last;
    logic clr_done;
  } stat_t;

  function automatic uc_t emit_word(input kind_t k, input vsel_t v, input logic sd);
    uc_t u;
    u           = '0;
    u.emit      = 1'b1;
    u.kind      = k;
    u.vsel      = v;
    u.sync_data = sd;
    u.cond      = C_NEXT;
    return u;
  endfunction

  // Microcode ROM
  function automatic uc_t ucode(input logic [3:0] s);
    uc_t u;
    u = '0;
    case (s)
      ST_IDLE: begin
        u.take_in = 1'b1;
        u.cond    = C_WAIT;
        u.target  = ST_ROW_SY;
      end
      ST_ROW_SY: u = emit_word(K_SYNC, V_ROW, 1'b0);
      ST_ROW_HI: u = emit_word(K_HI, V_ROW, 1'b0);
      ST_ROW_LO: u = emit_word(K_LO, V_ROW, 1'b0);
      ST_COL_SY: u = emit_word(K_SYNC, V_COL, 1'b0);
      ST_COL_HI: u = emit_word(K_HI, V_COL, 1'b0);
      ST_COL_LO: u = emit_word(K_LO, V_COL, 1'b0);
      ST_RD: begin
        u.rd   = 1'b1;
        u.cond = C_NEXT;
      end
      ST_WR: begin
        u.wr   = 1'b1;
        u.cond = C_NEXT;
      end
      ST_DH_SY: u = emit_word(K_SYNC, V_DHI, 1'b1);
      ST_DH_HI: u = emit_word(K_HI, V_DHI, 1'b1);
      ST_DH_LO: u = emit_word(K_LO, V_DHI, 1'b1);
      ST_DL_SY: u = emit_word(K_SYNC, V_DLO, 1'b1);
      ST_DL_HI: u = emit_word(K_HI, V_DLO, 1'b1);
      ST_DL_LO: begin
        u          = emit_word(K_LO, V_DLO, 1'b1);
        u.last_chk = 1'b1;
        u.cond     = C_LOOP;
        u.target   = ST_RD;
      end
      ST_CLR: begin
        u.clr    = 1'b1;
        u.cond   = C_CLR;
        u.target = ST_IDLE;
      end
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// File: rtl/lcdsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcdsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lcdsd_useq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`timescale 1ns / 1ps
module lcdsd_useq (
  input  logic              clk,
  input  logic              rst,
  input  lcdsd_pkg::stat_t  stat,
  output lcdsd_pkg::ctrl_t  ctrl
);

  logic [3:0]       step;
  logic [3:0]       step_next;
  lcdsd_pkg::uc_t   uc;
  logic             adv;

  // Decode the current control word and pick the next step
  always_comb begin
    uc        = lcdsd_pkg::ucode(step);
    step_next = step;
    adv       = 1'b0;
    case (uc.cond)
      lcdsd_pkg::C_NEXT: begin
        adv = !uc.emit || stat.out_free;
        if (adv) begin
          step_next = step + 4'd1;
        end
      end
      lcdsd_pkg::C_WAIT: begin
        adv = stat.in_fire;
        if (adv && !stat.in_skip) begin
          step_next = uc.target;
        end
      end
      lcdsd_pkg::C_LOOP: begin
        adv = stat.out_free;
        if (adv) begin
          step_next = stat.word_last ? lcdsd_pkg::ST_IDLE : uc.target;
        end
      end
      lcdsd_pkg::C_CLR: begin
        adv = stat.clr_done;
        if (adv) begin
          step_next = uc.target;
        end
      end
      default: begin
        adv       = 1'b0;
        step_next = lcdsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Gate the control word with the advance condition
  always_comb begin
    ctrl.take_in   = uc.take_in;
    ctrl.load_in   = uc.take_in && stat.in_fire;
    ctrl.emit_go   = uc.emit && adv;
    ctrl.kind      = uc.kind;
    ctrl.vsel      = uc.vsel;
    ctrl.sync_data = uc.sync_data;
    ctrl.last_chk  = uc.last_chk;
    ctrl.rd        = uc.rd;
    ctrl.wr        = uc.wr;
    ctrl.clr       = uc.clr;
    ctrl.w_inc     = (uc.cond == lcdsd_pkg::C_LOOP) && adv && !stat.word_last;
  end

  // Step counter; start with the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lcdsd_pkg::ST_CLR;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/lcdsd_dpath.sv
// Datapath: request registers, run mask, frame store, byte framing and output register.
`timescale 1ns / 1ps
module lcdsd_dpath (
  input  logic              clk,
  input  logic              rst,
  input  lcdsd_pkg::ctrl_t  ctrl,
  output lcdsd_pkg::stat_t  stat,
  input  logic              s_tvalid,
  input  logic [23:0]       s_tdata,
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);

  // Request fields
  logic       in_op;
  logic [6:0] in_xs;
  logic [6:0] in_xe;
  logic [5:0] in_row;
  logic       in_pix;

  // Normalized run
  logic [6:0] xa;
  logic [6:0] xb;
  logic [6:0] col_lo;
  logic [6:0] col_hi;
  logic       skip;

  // Held request
  logic [5:0] row;
  logic       pix_on;
  logic [2:0] ws;
  logic [2:0] we;
  logic [3:0] lo_bit;
  logic [3:0] hi_bit;
  logic [2:0] w;
  logic [15:0] word;

  // Frame store
  logic [lcdsd_pkg::FB_AW-1:0] clr_addr;
  logic                        ram_we;
  logic [lcdsd_pkg::FB_AW-1:0] ram_waddr;
  logic [15:0]                 ram_wdata;
  logic [15:0]                 ram_rdata;
  logic [3:0]                  m_lo;
  logic [3:0]                  m_hi;
  logic [15:0]                 mask;
  logic [15:0]                 upd;

  // Byte framing
  logic [7:0] val;
  logic [7:0] fbyte;

  assign in_op  = s_tuser;
  assign in_xs  = s_tdata[6:0];
  assign in_xe  = s_tdata[13:7];
  assign in_row = s_tdata[19:14];
  assign in_pix = s_tdata[20];

  // Swap reversed ends, saturate at the right edge, flag ignored requests
  always_comb begin
    xa     = in_xs;
    xb     = in_op ? in_xe : in_xs;
    col_lo = (xb < xa) ? xb : xa;
    col_hi = (xb < xa) ? xa : xb;
    if (col_lo > 7'(lcdsd_pkg::MAX_COL)) begin
      col_lo = 7'(lcdsd_pkg::MAX_COL);
    end
    if (col_hi > 7'(lcdsd_pkg::MAX_COL)) begin
      col_hi = 7'(lcdsd_pkg::MAX_COL);
    end
    skip = (7'(in_row) >= 7'(lcdsd_pkg::ROWS)) ||
           (!in_op && (in_xs > 7'(lcdsd_pkg::MAX_COL)));
  end

  assign stat.in_fire   = s_tvalid && ctrl.take_in;
  assign stat.in_skip   = skip;
  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.word_last = (w == we);
  assign stat.clr_done  = &clr_addr;

  // Capture the request; advance the word pointer
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      row    <= in_row;
      pix_on <= in_pix;
      ws     <= col_lo[6:4];
      we     <= col_hi[6:4];
      w      <= col_lo[6:4];
      lo_bit <= col_lo[3:0];
      hi_bit <= col_hi[3:0];
    end else if (ctrl.w_inc) begin
      w <= w + 3'd1;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Run mask for the current word and the updated word
  always_comb begin
    m_lo = (w == ws) ? lo_bit : 4'd0;
    m_hi = (w == we) ? hi_bit : 4'd15;
    mask = (16'hFFFF >> m_lo) & (16'hFFFF << (4'd15 - m_hi));
    upd  = pix_on ? (ram_rdata | mask) : (ram_rdata & ~mask);
  end

  // Write the updated word, or zero during the clearing pass
  always_comb begin
    ram_we    = ctrl.wr || ctrl.clr;
    ram_waddr = ctrl.clr ? clr_addr : {row, w};
    ram_wdata = ctrl.clr ? 16'h0000 : upd;
  end

  lcdsd_ram #(
    .WIDTH (lcdsd_pkg::FB_W),
    .DEPTH (lcdsd_pkg::FB_DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.rd),
    .raddr ({row, w}),
    .rdata (ram_rdata)
  );

  // Hold the updated word for its data bytes
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      word <= upd;
    end
  end

  // Select the byte to frame and the part that goes out
  always_comb begin
    case (ctrl.vsel)
      lcdsd_pkg::V_ROW: val = lcdsd_pkg::ADDR_BASE | {3'b000, row[4:0]};
      lcdsd_pkg::V_COL: val = lcdsd_pkg::ADDR_BASE | {4'b0000, row[5], ws};
      lcdsd_pkg::V_DHI: val = word[15:8];
      lcdsd_pkg::V_DLO: val = word[7:0];
      default:          val = '0;
    endcase
    case (ctrl.kind)
      lcdsd_pkg::K_SYNC: fbyte = ctrl.sync_data ? lcdsd_pkg::SYNC_DATA : lcdsd_pkg::SYNC_CMD;
      lcdsd_pkg::K_HI:   fbyte = {val[7:4], 4'h0};
      lcdsd_pkg::K_LO:   fbyte = {val[3:0], 4'h0};
      default:           fbyte = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_go) begin
      m_tdata <= fbyte;
      m_tlast <= ctrl.last_chk && (w == we);
    end
  end

endmodule

// File: rtl/mono_lcd_shadow_draw_serializer_top.sv
// Top level of the monochrome LCD shadow-buffer draw serializer.
// After a request is accepted, its first byte, the row sync, is registered into the output once the output is free.
// A request runs through the row and column command bytes, then, for each of its one to eight touched words,
// the read and write-back of the registered-read frame store plus six byte steps; no new request is taken meanwhile.
// An ignored request (row or pixel off screen) is taken and emits nothing.
// Reset: synchronous; the 512-entry frame store is zeroed by a clearing pass, with input held off.
`timescale 1ns / 1ps
module mono_lcd_shadow_draw_serializer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // x_start[6:0], x_end[13:7], row[19:14], pixel_value[20], zero
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // frame_byte[7:0]
  output logic        m_tlast
);

  lcdsd_pkg::ctrl_t ctrl;
  lcdsd_pkg::stat_t stat;

  assign s_tready = ctrl.take_in;

  lcdsd_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  lcdsd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: tb/tb_mono_lcd_shadow_draw_serializer_top.sv
// Self-checking testbench for the LCD shadow draw serializer: pixel and run requests.
`timescale 1ns / 1ps
module tb_mono_lcd_shadow_draw_serializer_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_RUN   = 1'b1
  } draw_op_t;

  typedef struct {
    draw_op_t   op;
    logic [6:0] x_start;
    logic [6:0] x_end;
    logic [5:0] row;
    logic       pixel_value;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
  } lcd_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // x_start[6:0], x_end[13:7], row[19:14], pixel_value[20], zero
  logic        s_tuser = 1'b0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // frame_byte[7:0]
  logic        m_tlast;

  // Shadow copy of the frame and the byte stream it predicts
  logic [15:0] frame_mem [lcdsd_pkg::FB_DEPTH];
  lcd_byte_t   lcd_stream_q [$];
  draw_req_t   pending_reqs [$];
  draw_req_t   cur_req;

  int err_count   = 0;
  int n_pixel     = 0;
  int n_run       = 0;
  int n_bytes     = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int stall_left  = 0;
  int calm_left   = 0;
  int idle_cycles = 0;

  mono_lcd_shadow_draw_serializer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  function automatic draw_req_t mk_req(input draw_op_t op, input int xs, input int xe,
                                       input int row, input logic val);
    draw_req_t r;
    r.op          = op;
    r.x_start     = xs[6:0];
    r.x_end       = xe[6:0];
    r.row         = row[5:0];
    r.pixel_value = val;
    return r;
  endfunction

  // Frame one command or data byte as sync, high nibble, low nibble
  task automatic push_framed(input logic [7:0] sync, input logic [7:0] b, input logic is_last);
    lcd_stream_q.push_back('{fbyte: sync, last: 1'b0});
    lcd_stream_q.push_back('{fbyte: {b[7:4], 4'h0}, last: 1'b0});
    lcd_stream_q.push_back('{fbyte: {b[3:0], 4'h0}, last: is_last});
  endtask

  // Update the shadow frame and queue the serial bytes one request causes
  task automatic predict_draw(input draw_req_t r);
    int          xs, xe, tmp, ws, we, lo, hi, idx;
    logic [15:0] mask;
    logic [7:0]  col_cmd;
    xs = r.x_start;
    xe = r.x_end;
    if (r.row >= lcdsd_pkg::ROWS) return;
    if (r.op == OP_PIXEL) begin
      if (xs > lcdsd_pkg::MAX_COL) return;
      xe = xs;
    end else begin
      if (xe < xs) begin
        tmp = xs;
        xs  = xe;
        xe  = tmp;
      end
      if (xs > lcdsd_pkg::MAX_COL) xs = lcdsd_pkg::MAX_COL;
      if (xe > lcdsd_pkg::MAX_COL) xe = lcdsd_pkg::MAX_COL;
    end
    ws = xs >> 4;
    we = xe >> 4;
    for (int w = ws; w <= we; w++) begin
      lo   = (w == ws) ? (xs & 15) : 0;
      hi   = (w == we) ? (xe & 15) : 15;
      mask = (16'hFFFF >> lo) & (16'hFFFF << (15 - hi));
      idx  = r.row * 8 + w;
      frame_mem[idx] = r.pixel_value ? (frame_mem[idx] | mask) : (frame_mem[idx] & ~mask);
    end
    col_cmd = lcdsd_pkg::ADDR_BASE + ws[7:0] + ((r.row >= 32) ? 8'd8 : 8'd0);
    push_framed(lcdsd_pkg::SYNC_CMD, lcdsd_pkg::ADDR_BASE + {3'b000, r.row[4:0]}, 1'b0);
    push_framed(lcdsd_pkg::SYNC_CMD, col_cmd, 1'b0);
    for (int w = ws; w <= we; w++) begin
      idx = r.row * 8 + w;
      push_framed(lcdsd_pkg::SYNC_DATA, frame_mem[idx][15:8], 1'b0);
      push_framed(lcdsd_pkg::SYNC_DATA, frame_mem[idx][7:0], w == we);
    end
  endtask

  // Drive request beats in bursts separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_draw(cur_req);
        if (cur_req.op == OP_PIXEL) n_pixel++;
        else n_run++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_tdata  <= {3'b000, cur_req.pixel_value, cur_req.row, cur_req.x_end, cur_req.x_start};
          s_tuser  <= cur_req.op;
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: short stalls, with calm stretches of steady ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      m_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          calm_left = $urandom_range(50, 200);
          m_tready <= 1'b1;
        end
        1, 2, 3: begin
          stall_left = $urandom_range(0, 7);
          m_tready <= 1'b0;
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Check each output beat against the oldest predicted byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (lcd_stream_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                 $time, m_tdata, m_tlast);
      end else begin
        n_bytes++;
        if (m_tdata !== lcd_stream_q[0].fbyte) begin
          err_count++;
          $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                   $time, lcd_stream_q[0].fbyte, m_tdata);
        end
        if (m_tlast !== lcd_stream_q[0].last) begin
          err_count++;
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, lcd_stream_q[0].last, m_tlast);
        end
        void'(lcd_stream_q.pop_front());
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int xs, xe, row;
    for (int i = 0; i < lcdsd_pkg::FB_DEPTH; i++) frame_mem[i] = '0;

    // Directed: corners, word edges, clears, reversed and full-width runs
    pending_reqs.push_back(mk_req(OP_PIXEL, 0, 0, 0, 1'b1));
    pending_reqs.push_back(mk_req(OP_PIXEL, 127, 0, 63, 1'b1));
    pending_reqs.push_back(mk_req(OP_PIXEL, 15, 0, 31, 1'b1));
    pending_reqs.push_back(mk_req(OP_PIXEL, 16, 0, 32, 1'b1));
    pending_reqs.push_back(mk_req(OP_PIXEL, 0, 0, 0, 1'b0));
    pending_reqs.push_back(mk_req(OP_PIXEL, 64, 127, 10, 1'b1));
    pending_reqs.push_back(mk_req(OP_PIXEL, 50, 0, 20, 1'b0));
    pending_reqs.push_back(mk_req(OP_RUN, 0, 127, 5, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 100, 20, 40, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 3, 12, 33, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 5, 9, 33, 1'b0));
    pending_reqs.push_back(mk_req(OP_RUN, 77, 77, 62, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 0, 0, 0, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 127, 127, 63, 1'b0));
    pending_reqs.push_back(mk_req(OP_RUN, 15, 16, 1, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 127, 0, 32, 1'b1));
    pending_reqs.push_back(mk_req(OP_RUN, 120, 8, 32, 1'b0));
    pending_reqs.push_back(mk_req(OP_RUN, 0, 127, 5, 1'b0));

    // Random: pixels and runs, mostly on a few busy rows so words get rewritten
    repeat (200) begin
      row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : 8 * $urandom_range(0, 7) + 3;
      xs  = $urandom_range(0, 127);
      case ($urandom_range(0, 9))
        0, 1, 2: xe = $urandom_range(0, 127);
        3, 4, 5, 6: xe = (xs + $urandom_range(0, 20) > 127) ? 127 : xs + $urandom_range(0, 20);
        default: xe = (xs & 7'h70) + $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 3) == 0) pending_reqs.push_back(mk_req(OP_RUN, xe, xs, row,
                                                                  1'($urandom_range(0, 1))));
      else if ($urandom_range(0, 2) == 0) pending_reqs.push_back(mk_req(OP_PIXEL, xs, xe, row,
                                                                       1'($urandom_range(0, 1))));
      else pending_reqs.push_back(mk_req(OP_RUN, xs, xe, row, 1'($urandom_range(0, 1))));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every predicted byte to come out
    while (pending_reqs.size() != 0 || s_tvalid || lcd_stream_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pixel and %0d run requests, %0d serial bytes compared.",
             n_pixel, n_run, n_bytes);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
